// File: rtl/dhcptlv_pkg.sv
// dhcptlv_pkg: option codes, overload bits and parse phase type for the
// dhcp option tlv parser and its port checker. depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dhcptlv_pkg;

  localparam int unsigned MAX_REGION_BYTES_DEF = 2048;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_OVERLOAD = 8'd52;

  localparam int unsigned OVL_FILE_BIT  = 0;
  localparam int unsigned OVL_SNAME_BIT = 1;

  localparam logic [1:0] REGION_OPTIONS = 2'd0;
  localparam logic [1:0] REGION_FILE    = 2'd1;
  localparam logic [1:0] REGION_SNAME   = 2'd2;
  localparam logic [1:0] REGION_NONE    = 2'd3;

  typedef enum logic [2:0] {
    PH_CODE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

endpackage

`default_nettype wire

// File: rtl/dhcp_option_tlv_parser.sv
// dhcp_option_tlv_parser: walks the options, file and sname regions of a
// dhcp message one byte per transfer and emits option data bytes and
// zero-length option results. depends on dhcptlv_pkg.
//
// usage
//   input channel: one message byte per transfer, tagged with its region
//   (0 options, 1 file, 2 sname), the region's usable size and a flag on the
//   first byte of each region. a first byte on region 0 starts a new message.
//   output channel: at most one result per input byte: code, declared length,
//   data offset, data byte and flags of one option.
//   a result is shown in the cycle after the input transfer that causes
//   it. throughput: one byte per cycle; the parse state updates in
//   the same cycle the byte is taken, and the result sits in an output
//   register, so the next byte is taken while a result waits, as long as
//   the receiver takes that result in the same cycle.
//   stall: when the output register holds a result the receiver has not
//   taken, in_ready drops and the parse state holds.
//   reset: rst_n low for one clock clears the parse state, the region
//   enables and the output valid, and sets the overload permission.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_option_tlv_parser #(
  parameter int unsigned MAX_REGION_BYTES = dhcptlv_pkg::MAX_REGION_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_first_of_region,
  input  wire logic [1:0]  in_region,
  input  wire logic [10:0] in_region_size,
  input  wire logic [7:0]  in_data_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_option_code,
  output logic [7:0]       out_option_length,
  output logic [7:0]       out_data_offset,
  output logic [7:0]       out_value_byte,
  output logic             out_has_data,
  output logic             out_last_of_option,
  output logic [1:0]       out_source_region
);

  localparam int unsigned SIZE_CAP = (MAX_REGION_BYTES < 2047) ? MAX_REGION_BYTES : 2047;
  localparam int unsigned POS_W    = $clog2(SIZE_CAP + 1);
  localparam int unsigned SUM_W    = ((POS_W > 8) ? POS_W : 8) + 2;

  // parse state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  dhcptlv_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]          code_r, code_nxt;
  logic [7:0]          len_r, len_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic                stop_r, stop_nxt;
  logic                fen_r, fen_nxt;
  logic                sen_r, sen_nxt;
  logic                ovl_r, ovl_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          code_o_r, len_o_r, off_o_r, val_o_r;
  logic                hasd_o_r, last_o_r;
  logic [1:0]          reg_o_r;

  logic                in_xfer;
  logic [POS_W-1:0]    size_c;
  logic                enabled;
  logic                emit;
  logic [7:0]          off_c, val_c;
  logic                hasd_c, last_c;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_region_size > 11'(SIZE_CAP)) begin
      size_c = POS_W'(SIZE_CAP);
    end else begin
      size_c = POS_W'(in_region_size);
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    stop_nxt  = stop_r;
    fen_nxt   = fen_r;
    sen_nxt   = sen_r;
    ovl_nxt   = ovl_r;
    enabled   = 1'b0;
    emit      = 1'b0;
    off_c     = 8'd0;
    val_c     = 8'd0;
    hasd_c    = 1'b0;
    last_c    = 1'b0;
    if (in_xfer && in_region != dhcptlv_pkg::REGION_NONE) begin
      if (in_first_of_region) begin
        pos_nxt   = '0;
        phase_nxt = dhcptlv_pkg::PH_CODE;
        code_nxt  = 8'd0;
        len_nxt   = 8'd0;
        cnt_nxt   = 8'd0;
        stop_nxt  = 1'b0;
        if (in_region == dhcptlv_pkg::REGION_OPTIONS) begin
          fen_nxt = 1'b0;
          sen_nxt = 1'b0;
          ovl_nxt = 1'b1;
        end else begin
          ovl_nxt = 1'b0;
        end
      end
      enabled = (in_region == dhcptlv_pkg::REGION_OPTIONS)
             || (in_region == dhcptlv_pkg::REGION_FILE && fen_nxt)
             || (in_region == dhcptlv_pkg::REGION_SNAME && sen_nxt);
      if (enabled && !stop_nxt) begin
        if (pos_nxt >= size_c) begin
          stop_nxt = 1'b1;
        end else begin
          case (phase_nxt)
            dhcptlv_pkg::PH_CODE: begin
              if (in_data_byte == dhcptlv_pkg::OPT_PAD) begin
                pos_nxt = pos_nxt + POS_W'(1);
              end else if (in_data_byte == dhcptlv_pkg::OPT_END
                           || (SUM_W'(pos_nxt) + SUM_W'(2)) > SUM_W'(size_c)) begin
                stop_nxt = 1'b1;
              end else begin
                code_nxt  = in_data_byte;
                phase_nxt = dhcptlv_pkg::PH_LEN;
                pos_nxt   = pos_nxt + POS_W'(1);
              end
            end
            dhcptlv_pkg::PH_LEN: begin
              if ((SUM_W'(pos_nxt) + SUM_W'(1) + SUM_W'(in_data_byte)) > SUM_W'(size_c)) begin
                stop_nxt = 1'b1;
              end else begin
                len_nxt = in_data_byte;
                cnt_nxt = 8'd0;
                pos_nxt = pos_nxt + POS_W'(1);
                if (in_data_byte == 8'd0) begin
                  phase_nxt = dhcptlv_pkg::PH_CODE;
                  if (code_nxt != dhcptlv_pkg::OPT_OVERLOAD) begin
                    emit   = 1'b1;
                    last_c = 1'b1;
                  end
                end else begin
                  phase_nxt = dhcptlv_pkg::PH_DATA;
                end
              end
            end
            default: begin
              off_c   = cnt_nxt;
              last_c  = ({1'b0, cnt_nxt} + 9'd1) >= {1'b0, len_nxt};
              pos_nxt = pos_nxt + POS_W'(1);
              if (code_nxt == dhcptlv_pkg::OPT_OVERLOAD) begin
                if (len_nxt == 8'd1 && in_region == dhcptlv_pkg::REGION_OPTIONS
                    && ovl_nxt) begin
                  if (in_data_byte[dhcptlv_pkg::OVL_FILE_BIT]) begin
                    fen_nxt = 1'b1;
                  end
                  if (in_data_byte[dhcptlv_pkg::OVL_SNAME_BIT]) begin
                    sen_nxt = 1'b1;
                  end
                end
              end else begin
                emit   = 1'b1;
                val_c  = in_data_byte;
                hasd_c = 1'b1;
              end
              if (last_c) begin
                phase_nxt = dhcptlv_pkg::PH_CODE;
                cnt_nxt   = 8'd0;
              end else begin
                cnt_nxt = cnt_nxt + 8'd1;
              end
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= dhcptlv_pkg::PH_CODE;
      code_r      <= 8'd0;
      len_r       <= 8'd0;
      cnt_r       <= 8'd0;
      stop_r      <= 1'b0;
      fen_r       <= 1'b0;
      sen_r       <= 1'b0;
      ovl_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      code_r      <= code_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      fen_r       <= fen_nxt;
      sen_r       <= sen_nxt;
      ovl_r       <= ovl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      code_o_r <= code_nxt;
      len_o_r  <= len_nxt;
      off_o_r  <= off_c;
      val_o_r  <= val_c;
      hasd_o_r <= hasd_c;
      last_o_r <= last_c;
      reg_o_r  <= in_region;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_option_code    = code_o_r;
  assign out_option_length  = len_o_r;
  assign out_data_offset    = off_o_r;
  assign out_value_byte     = val_o_r;
  assign out_has_data       = hasd_o_r;
  assign out_last_of_option = last_o_r;
  assign out_source_region  = reg_o_r;

endmodule

`default_nettype wire

// File: rtl/dhcptlv_checker.sv
// dhcptlv_checker: port-level assertions for dhcp_option_tlv_parser, bound
// to it by the bind below. depends on dhcptlv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhcptlv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_option_code,
  input wire logic [7:0]  out_option_length,
  input wire logic [7:0]  out_data_offset,
  input wire logic [7:0]  out_value_byte,
  input wire logic        out_has_data,
  input wire logic        out_last_of_option,
  input wire logic [1:0]  out_source_region
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_option_code)
      && $stable(out_data_offset) && $stable(out_value_byte)
      && $stable(out_last_of_option))
    else $error("stalled result changed");

  // a zero-length option is one result with no data
  a_no_data_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last_of_option && out_option_length == 8'd0
      && out_value_byte == 8'd0 && out_data_offset == 8'd0)
    else $error("malformed zero-length result");

  // no result for pad, end, overload or region none; offsets stay in the option
  a_code_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_option_code != dhcptlv_pkg::OPT_PAD
      && out_option_code != dhcptlv_pkg::OPT_END
      && out_option_code != dhcptlv_pkg::OPT_OVERLOAD
      && out_source_region != dhcptlv_pkg::REGION_NONE
      && (!out_has_data || out_data_offset < out_option_length))
    else $error("result for a code or offset that is never reported");

  // a waiting result that is not taken blocks the input
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind dhcp_option_tlv_parser dhcptlv_checker u_dhcptlv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_option_code    (out_option_code),
  .out_option_length  (out_option_length),
  .out_data_offset    (out_data_offset),
  .out_value_byte     (out_value_byte),
  .out_has_data       (out_has_data),
  .out_last_of_option (out_last_of_option),
  .out_source_region  (out_source_region)
);

`default_nettype wire

// File: verif/dhcp_option_tlv_checker.sv
// dhcp_option_tlv_checker: watches both channels of the dhcp option tlv
// parser, predicts each option result and compares it. depends on dhcptlv_pkg.
`timescale 1ns / 1ps

module dhcp_option_tlv_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_first_of_region,
  input  logic [1:0]  in_region,
  input  logic [10:0] in_region_size,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_option_code,
  input  logic [7:0]  out_option_length,
  input  logic [7:0]  out_data_offset,
  input  logic [7:0]  out_value_byte,
  input  logic        out_has_data,
  input  logic        out_last_of_option,
  input  logic [1:0]  out_source_region,
  output int          mismatches,
  output int          results_pending
);

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] length;
    logic [7:0] offset;
    logic [7:0] value;
    logic       has_data;
    logic       last;
    logic [1:0] region;
  } option_byte_t;

  option_byte_t option_bytes_q[$];
  option_byte_t want;
  option_byte_t got;
  option_byte_t predicted;

  int unsigned         region_pos;
  dhcptlv_pkg::phase_t phase;
  logic [7:0]          held_code;
  logic [7:0]          held_len;
  logic [7:0]          data_cnt;
  logic                stopped;
  logic                file_en;
  logic                sname_en;
  logic                overload_ok;
  int                  results_seen;

  function automatic void clear_parser();
    region_pos  = 0;
    phase       = dhcptlv_pkg::PH_CODE;
    held_code   = '0;
    held_len    = '0;
    data_cnt    = '0;
    stopped     = 1'b0;
    file_en     = 1'b0;
    sname_en    = 1'b0;
    overload_ok = 1'b1;
  endfunction

  // advances the parse by one byte, returns 1 when an option result follows
  function automatic bit parse_byte(input logic first, input logic [1:0] rg,
                                    input logic [10:0] size, input logic [7:0] b,
                                    output option_byte_t r);
    int unsigned pos;
    bit enabled;
    bit emit;
    bit fin;
    r = '0;
    emit = 1'b0;
    fin = 1'b0;
    if (rg == dhcptlv_pkg::REGION_NONE) return 1'b0;
    if (first) begin
      region_pos = 0;
      phase      = dhcptlv_pkg::PH_CODE;
      held_code  = '0;
      held_len   = '0;
      data_cnt   = '0;
      stopped    = 1'b0;
      if (rg == dhcptlv_pkg::REGION_OPTIONS) begin
        file_en     = 1'b0;
        sname_en    = 1'b0;
        overload_ok = 1'b1;
      end else begin
        overload_ok = 1'b0;
      end
    end
    enabled = (rg == dhcptlv_pkg::REGION_OPTIONS) ||
              (rg == dhcptlv_pkg::REGION_FILE && file_en) ||
              (rg == dhcptlv_pkg::REGION_SNAME && sname_en);
    if (!enabled || stopped) return 1'b0;
    pos = region_pos;
    if (pos >= size) begin
      stopped = 1'b1;
      return 1'b0;
    end
    case (phase)
      dhcptlv_pkg::PH_CODE: begin
        if (b == dhcptlv_pkg::OPT_PAD) begin
          region_pos = pos + 1;
        end else if (b == dhcptlv_pkg::OPT_END || pos + 2 > size) begin
          stopped = 1'b1;
        end else begin
          held_code  = b;
          phase      = dhcptlv_pkg::PH_LEN;
          region_pos = pos + 1;
        end
      end
      dhcptlv_pkg::PH_LEN: begin
        if (pos + 1 + b > size) begin
          stopped = 1'b1;
        end else begin
          held_len   = b;
          data_cnt   = '0;
          region_pos = pos + 1;
          if (b == 8'd0) begin
            phase = dhcptlv_pkg::PH_CODE;
            fin   = 1'b1;
            emit  = (held_code != dhcptlv_pkg::OPT_OVERLOAD);
          end else begin
            phase = dhcptlv_pkg::PH_DATA;
          end
        end
      end
      default: begin
        r.offset   = data_cnt;
        fin        = (int'(data_cnt) + 1 >= int'(held_len));
        region_pos = pos + 1;
        if (held_code == dhcptlv_pkg::OPT_OVERLOAD) begin
          if (held_len == 8'd1 && rg == dhcptlv_pkg::REGION_OPTIONS && overload_ok) begin
            if (b[dhcptlv_pkg::OVL_FILE_BIT]) file_en = 1'b1;
            if (b[dhcptlv_pkg::OVL_SNAME_BIT]) sname_en = 1'b1;
          end
        end else begin
          emit       = 1'b1;
          r.value    = b;
          r.has_data = 1'b1;
        end
        if (fin) begin
          phase    = dhcptlv_pkg::PH_CODE;
          data_cnt = '0;
        end else begin
          data_cnt = data_cnt + 8'd1;
        end
      end
    endcase
    r.code   = held_code;
    r.length = held_len;
    r.last   = fin;
    r.region = rg;
    return emit;
  endfunction

  function automatic string show(input option_byte_t r);
    return $sformatf("code %0d len %0d off %0d val %0d data %0b last %0b region %0d",
                     r.code, r.length, r.offset, r.value, r.has_data, r.last, r.region);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      option_bytes_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_option_code, out_option_length, out_data_offset, out_value_byte,
                out_has_data, out_last_of_option, out_source_region};
        if (option_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with none predicted: %s", results_seen, show(got));
        end else begin
          want = option_bytes_q.pop_front();
          if (got.code !== want.code || got.length !== want.length ||
              got.offset !== want.offset || got.value !== want.value ||
              got.has_data !== want.has_data || got.last !== want.last ||
              got.region !== want.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %s, got %s", results_seen, show(want),
                       show(got));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_first_of_region, in_region, in_region_size, in_data_byte,
                       predicted))
          option_bytes_q.push_back(predicted);
      end
    end
    results_pending = option_bytes_q.size();
  end

endmodule

// File: verif/dhcp_option_tlv_parser_tb.sv
// dhcp_option_tlv_parser_tb: drives directed and random dhcp option regions
// into the parser and gives the verdict. depends on dhcptlv_pkg,
// dhcp_option_tlv_parser and dhcp_option_tlv_checker.
`timescale 1ns / 1ps

module dhcp_option_tlv_parser_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_first_of_region;
  logic [1:0]  in_region;
  logic [10:0] in_region_size;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_option_code;
  logic [7:0]  out_option_length;
  logic [7:0]  out_data_offset;
  logic [7:0]  out_value_byte;
  logic        out_has_data;
  logic        out_last_of_option;
  logic [1:0]  out_source_region;

  int mismatches;
  int results_pending;
  int cycle_count = 0;
  int bytes_sent = 0;
  int in_idle_pct = 6;
  int out_stall_pct = 6;
  logic [7:0] region_bytes[$];

  dhcp_option_tlv_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_first_of_region (in_first_of_region),
    .in_region          (in_region),
    .in_region_size     (in_region_size),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_option_code    (out_option_code),
    .out_option_length  (out_option_length),
    .out_data_offset    (out_data_offset),
    .out_value_byte     (out_value_byte),
    .out_has_data       (out_has_data),
    .out_last_of_option (out_last_of_option),
    .out_source_region  (out_source_region)
  );

  dhcp_option_tlv_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_first_of_region (in_first_of_region),
    .in_region          (in_region),
    .in_region_size     (in_region_size),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_option_code    (out_option_code),
    .out_option_length  (out_option_length),
    .out_data_offset    (out_data_offset),
    .out_value_byte     (out_value_byte),
    .out_has_data       (out_has_data),
    .out_last_of_option (out_last_of_option),
    .out_source_region  (out_source_region),
    .mismatches         (mismatches),
    .results_pending    (results_pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dhcp_option_tlv_parser: mismatch");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic first, input logic [1:0] rg,
                           input logic [10:0] size, input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_first_of_region <= first;
    in_region          <= rg;
    in_region_size     <= size;
    in_data_byte       <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic fill_region(input int target);
    int k;
    int len;
    bit done;
    logic [7:0] code;
    region_bytes.delete();
    done = 1'b0;
    while (!done && region_bytes.size() < target) begin
      k = $urandom_range(99);
      if (k < 10) begin
        region_bytes.push_back(dhcptlv_pkg::OPT_PAD);
      end else if (k < 14) begin
        region_bytes.push_back(dhcptlv_pkg::OPT_END);
        repeat ($urandom_range(2)) region_bytes.push_back(8'($urandom));
        done = 1'b1;
      end else if (k < 22) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(3) : 1;
        region_bytes.push_back(dhcptlv_pkg::OPT_OVERLOAD);
        region_bytes.push_back(8'(len));
        repeat (len) region_bytes.push_back(8'($urandom));
      end else begin
        code = 8'($urandom_range(1, 254));
        len = ($urandom_range(49) == 0) ? $urandom_range(128, 255) : $urandom_range(8);
        region_bytes.push_back(code);
        region_bytes.push_back(8'(len));
        repeat (len) region_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic send_region(input logic [1:0] rg, input bit mark_first);
    int len;
    int size;
    int sel;
    len = region_bytes.size();
    sel = $urandom_range(9);
    if (sel < 6) size = len;
    else if (sel < 8) size = len - $urandom_range(3);
    else if (sel == 8) size = len + $urandom_range(1, 4);
    else size = $urandom_range(len, 2047);
    if (size < 0) size = 0;
    foreach (region_bytes[i])
      send_byte(mark_first && i == 0, rg, 11'(size), region_bytes[i]);
  endtask

  task automatic send_message();
    fill_region($urandom_range(1, 40));
    if ($urandom_range(9) < 7) begin
      region_bytes.push_front(8'($urandom));
      region_bytes.push_front(8'd1);
      region_bytes.push_front(dhcptlv_pkg::OPT_OVERLOAD);
    end
    send_region(dhcptlv_pkg::REGION_OPTIONS, $urandom_range(19) != 0);
    if ($urandom_range(9) < 8) begin
      fill_region($urandom_range(1, 30));
      send_region(dhcptlv_pkg::REGION_FILE, $urandom_range(19) != 0);
    end
    if ($urandom_range(9) < 8) begin
      fill_region($urandom_range(1, 30));
      send_region(dhcptlv_pkg::REGION_SNAME, $urandom_range(19) != 0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_byte(1'($urandom_range(1)), 2'($urandom_range(3)), 11'($urandom_range(2047)),
                8'($urandom_range(255)));
  endtask

  initial begin
    int pick;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_first_of_region = 1'b0;
    in_region          = dhcptlv_pkg::REGION_OPTIONS;
    in_region_size     = '0;
    in_data_byte       = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pad, overload enabling both, zero-length option, data option, end code
    send_byte(1'b1, dhcptlv_pkg::REGION_OPTIONS, 11'd14, dhcptlv_pkg::OPT_PAD);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, dhcptlv_pkg::OPT_OVERLOAD);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'd1);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'h03);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'd7);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'd0);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'd200);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'd2);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'hFF);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'h00);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, dhcptlv_pkg::OPT_END);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd14, 8'h11);
    // file region filled exactly, then a byte past its size
    send_byte(1'b1, dhcptlv_pkg::REGION_FILE, 11'd3, 8'd9);
    send_byte(1'b0, dhcptlv_pkg::REGION_FILE, 11'd3, 8'd1);
    send_byte(1'b0, dhcptlv_pkg::REGION_FILE, 11'd3, 8'hAA);
    send_byte(1'b0, dhcptlv_pkg::REGION_FILE, 11'd3, 8'h5A);
    // sname body runs past the region end
    send_byte(1'b1, dhcptlv_pkg::REGION_SNAME, 11'd2, 8'd33);
    send_byte(1'b0, dhcptlv_pkg::REGION_SNAME, 11'd2, 8'd5);
    send_byte(1'b0, dhcptlv_pkg::REGION_SNAME, 11'd2, 8'd3);
    // header past end, zero-length at end, unenabled file, region none, empty region
    send_byte(1'b1, dhcptlv_pkg::REGION_OPTIONS, 11'd1, 8'd8);
    send_byte(1'b1, dhcptlv_pkg::REGION_OPTIONS, 11'd2, 8'd6);
    send_byte(1'b0, dhcptlv_pkg::REGION_OPTIONS, 11'd2, 8'd0);
    send_byte(1'b1, dhcptlv_pkg::REGION_FILE, 11'd4, 8'd1);
    send_byte(1'b1, dhcptlv_pkg::REGION_NONE, 11'd2047, 8'hFF);
    send_byte(1'b1, dhcptlv_pkg::REGION_OPTIONS, 11'd0, 8'd1);
    drain_results();

    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= 600 && bytes_sent < 900) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct   = 6;
        out_stall_pct = 6;
      end
      pick = $urandom_range(99);
      if (pick < 8) send_noise();
      else send_message();
      if (pick >= 95) drain_results();
    end
    drain_results();
    repeat (8) @(negedge clk);

    if (mismatches == 0 && results_pending == 0)
      $display("dhcp_option_tlv_parser: match");
    else
      $display("dhcp_option_tlv_parser: mismatch");
    $finish;
  end

endmodule
